@@ rtl/lss_pkg.sv @@
`default_nettype none

package lss_pkg;

   localparam int PIXEL_W   = 24;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int COUNT_W   = 8;
   localparam int PAD_W     = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam int DEF_TICK_WIDTH = 16;
   localparam int DEF_FRAME_BITS = 24;

   localparam logic [COUNT_W-1:0] RST_LED_COUNT  = 8'd16;
   localparam logic [CSR_W-1:0]   RST_ONE_HIGH   = 16'd80;
   localparam logic [CSR_W-1:0]   RST_ONE_LOW    = 16'd45;
   localparam logic [CSR_W-1:0]   RST_ZERO_HIGH  = 16'd40;
   localparam logic [CSR_W-1:0]   RST_ZERO_LOW   = 16'd85;
   localparam logic [CSR_W-1:0]   RST_GAP        = 16'd5000;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   localparam logic [PAD_W-1:0] PAD_ONE   = 2'd1;
   localparam logic [PAD_W-1:0] PAD_THREE = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LED_COUNT = 3'd0,
      CSR_ONE_HIGH  = 3'd1,
      CSR_ONE_LOW   = 3'd2,
      CSR_ZERO_HIGH = 3'd3,
      CSR_ZERO_LOW  = 3'd4,
      CSR_GAP       = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2,
      PH_GAP  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0] led_count;
      logic [CSR_W-1:0]   one_high;
      logic [CSR_W-1:0]   one_low;
      logic [CSR_W-1:0]   zero_high;
      logic [CSR_W-1:0]   zero_low;
      logic [CSR_W-1:0]   gap;
   } cfg_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic line;
   } res_type;

endpackage

`default_nettype wire

@@ rtl/lss_csr.sv @@
`default_nettype none

module lss_csr
   import lss_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LED_COUNT: cfg_in.led_count = csr_wdata[COUNT_W-1:0];
            CSR_ONE_HIGH:  cfg_in.one_high  = csr_wdata;
            CSR_ONE_LOW:   cfg_in.one_low   = csr_wdata;
            CSR_ZERO_HIGH: cfg_in.zero_high = csr_wdata;
            CSR_ZERO_LOW:  cfg_in.zero_low  = csr_wdata;
            CSR_GAP:       cfg_in.gap       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count <= RST_LED_COUNT;
         cfg_ff.one_high  <= RST_ONE_HIGH;
         cfg_ff.one_low   <= RST_ONE_LOW;
         cfg_ff.zero_high <= RST_ZERO_HIGH;
         cfg_ff.zero_low  <= RST_ZERO_LOW;
         cfg_ff.gap       <= RST_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/lss_core.sv @@
`default_nettype none

module lss_core
   import lss_pkg::*;
#(
   parameter int TICK_WIDTH = DEF_TICK_WIDTH,
   parameter int FRAME_BITS = DEF_FRAME_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               step,
   input  wire logic               kind,
   input  wire logic [PIXEL_W-1:0] pixel_word,
   input  wire logic               lights_on,
   input  wire logic [PAD_W-1:0]   pad_mode,
   output res_type                 res,
   output logic                    idle
);

   localparam int CMP_W     = (TICK_WIDTH > CSR_W) ? TICK_WIDTH : CSR_W;
   localparam int BIT_IDX_W = $clog2(FRAME_BITS);
   localparam logic [BIT_IDX_W-1:0]  LAST_BIT = BIT_IDX_W'(FRAME_BITS - 1);
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

   phase_type               phase_ff, phase_in;
   logic [COUNT_W-1:0]      led_index_ff, led_index_in;
   logic [1:0]              frame_in_led_ff, frame_in_led_in;
   logic [BIT_IDX_W-1:0]    bit_index_ff, bit_index_in;
   logic [TICK_WIDTH-1:0]   tick_count_ff, tick_count_in;
   logic [FRAME_BITS-1:0]   frame_shift_ff, frame_shift_in;
   logic [PIXEL_W-1:0]      held_pixel_ff, held_pixel_in;
   logic                    held_lights_ff, held_lights_in;
   logic [PAD_W-1:0]        held_pad_ff, held_pad_in;

   logic                    cur_bit;
   logic [CSR_W-1:0]        tick_len;
   logic [TICK_WIDTH-1:0]   tick_next;
   logic                    tick_end;
   logic [1:0]              last_frame;
   logic [COUNT_W-1:0]      led_next;

   assign cur_bit = frame_shift_ff[FRAME_BITS-1];

   always_comb begin
      if (phase_ff == PH_HIGH) begin
         tick_len = cur_bit ? cfg.one_high : cfg.zero_high;
      end else if (phase_ff == PH_LOW) begin
         tick_len = cur_bit ? cfg.one_low : cfg.zero_low;
      end else begin
         tick_len = cfg.gap;
      end
   end

   assign tick_next = (tick_count_ff != TICK_MAX) ? tick_count_ff + 1'b1 : tick_count_ff;
   assign tick_end  = (CMP_W'(tick_next) >= CMP_W'(tick_len)) || (tick_next == TICK_MAX);

   // index of the last frame sent per led, padding included
   always_comb begin
      last_frame = 2'd0;
      if (held_lights_ff) begin
         if (held_pad_ff == PAD_ONE) begin
            last_frame = 2'd1;
         end else if (held_pad_ff == PAD_THREE) begin
            last_frame = 2'd3;
         end
      end
   end

   assign led_next = led_index_ff + 1'b1;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      led_index_in    = led_index_ff;
      frame_in_led_in = frame_in_led_ff;
      bit_index_in    = bit_index_ff;
      tick_count_in   = tick_count_ff;
      frame_shift_in  = frame_shift_ff;
      held_pixel_in   = held_pixel_ff;
      held_lights_in  = held_lights_ff;
      held_pad_in     = held_pad_ff;
      if (step) begin
         if (kind == KIND_START) begin
            if (phase_ff == PH_IDLE) begin
               held_pixel_in   = pixel_word;
               held_lights_in  = lights_on;
               held_pad_in     = pad_mode;
               led_index_in    = '0;
               frame_in_led_in = '0;
               bit_index_in    = '0;
               tick_count_in   = '0;
               if (cfg.led_count == '0) begin
                  frame_shift_in = '0;
                  phase_in       = PH_GAP;
               end else begin
                  frame_shift_in = lights_on ? FRAME_BITS'(pixel_word) : '0;
                  phase_in       = PH_HIGH;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_HIGH: begin
                  if (tick_end) begin
                     tick_count_in = '0;
                     phase_in      = PH_LOW;
                  end else begin
                     tick_count_in = tick_next;
                  end
               end
               PH_LOW: begin
                  if (tick_end) begin
                     tick_count_in = '0;
                     if (bit_index_ff != LAST_BIT) begin
                        bit_index_in   = bit_index_ff + 1'b1;
                        frame_shift_in = frame_shift_ff << 1;
                        phase_in       = PH_HIGH;
                     end else begin
                        bit_index_in = '0;
                        if (frame_in_led_ff != last_frame) begin
                           frame_in_led_in = frame_in_led_ff + 1'b1;
                           frame_shift_in  = '0;
                           phase_in        = PH_HIGH;
                        end else begin
                           frame_in_led_in = '0;
                           led_index_in    = led_next;
                           if (led_next != '0 && led_next < cfg.led_count) begin
                              frame_shift_in = held_lights_ff ?
                                               FRAME_BITS'(held_pixel_ff) : '0;
                              phase_in       = PH_HIGH;
                           end else begin
                              frame_shift_in = frame_shift_ff << 1;
                              phase_in       = PH_GAP;
                           end
                        end
                     end
                  end else begin
                     tick_count_in = tick_next;
                  end
               end
               PH_GAP: begin
                  if (tick_end) begin
                     tick_count_in = '0;
                     led_index_in  = '0;
                     phase_in      = PH_IDLE;
                  end else begin
                     tick_count_in = tick_next;
                  end
               end
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      res.line = (phase_in == PH_HIGH);
      res.busy = (phase_in != PH_IDLE);
      res.done = step && (kind == KIND_TICK) && (phase_ff == PH_GAP) && tick_end;
      idle     = (phase_ff == PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         led_index_ff    <= '0;
         frame_in_led_ff <= '0;
         bit_index_ff    <= '0;
         tick_count_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         led_index_ff    <= led_index_in;
         frame_in_led_ff <= frame_in_led_in;
         bit_index_ff    <= bit_index_in;
         tick_count_ff   <= tick_count_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_shift_ff <= frame_shift_in;
      held_pixel_ff  <= held_pixel_in;
      held_lights_ff <= held_lights_in;
      held_pad_ff    <= held_pad_in;
   end

endmodule

`default_nettype wire

@@ rtl/addressable_led_strip_serializer.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/req_tready | tuser kind, tdata pixel/flags
// rsp     | out       | rsp_tvalid/rsp_tready | tdata line/busy/done
// csr     | in        | csr_we                | csr_index, csr_wdata
// one beat per cycle unless rsp stalls; a taken beat waits in the input register
// the serializer state updates as a beat moves from the input register to rsp
// reset is synchronous and leaves the line idle with csr registers at defaults
// a stall on rsp fills the input register, then drops req_tready
`default_nettype none

module addressable_led_strip_serializer
   import lss_pkg::*;
#(
   parameter int TICK_WIDTH = DEF_TICK_WIDTH,
   parameter int FRAME_BITS = DEF_FRAME_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // pixel_word, lights_on, pad_mode
   input  wire logic                  req_tuser,  // kind
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // line_level, busy_res, done_res
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   cfg_type            cfg;
   res_type            step_res;
   logic               core_idle;

   logic               s1_valid_ff;
   logic               s1_kind_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_lights_ff;
   logic [PAD_W-1:0]   s1_pad_ff;
   logic               rsp_valid_ff;
   res_type            rsp_res_ff;
   logic               adv;

   assign adv        = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || adv;

   lss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lss_core #(
      .TICK_WIDTH (TICK_WIDTH),
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (adv),
      .kind       (s1_kind_ff),
      .pixel_word (s1_pixel_ff),
      .lights_on  (s1_lights_ff),
      .pad_mode   (s1_pad_ff),
      .res        (step_res),
      .idle       (core_idle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff   <= req_tuser;
         s1_pixel_ff  <= req_tdata[PIXEL_W-1:0];
         s1_lights_ff <= req_tdata[PIXEL_W];
         s1_pad_ff    <= req_tdata[PIXEL_W+PAD_W:PIXEL_W+1];
      end
      if (adv) begin
         rsp_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_res_ff.done, rsp_res_ff.busy, rsp_res_ff.line});

   a_ready_only_on_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stage stalled without a blocked result");

   a_tick_in_idle : assert property (@(posedge clock) disable iff (reset)
      (adv && s1_kind_ff == KIND_TICK && core_idle) |=>
         (rsp_tvalid && !rsp_res_ff.busy && !rsp_res_ff.done && !rsp_res_ff.line))
      else $error("tick beat while idle changed the result");

   a_done_returns_idle : assert property (@(posedge clock) disable iff (reset)
      (adv && step_res.done) |=> (core_idle && rsp_tvalid && !rsp_res_ff.busy))
      else $error("done pulse without return to idle");

endmodule

`default_nettype wire
